// ----- rtl/core/rtaac_pkg.sv -----
// Package for the admission control block: sizes, status and command codes,
// sequencer states. No dependencies.
package rtaac_pkg;

    localparam int TASK_SLOTS = 32;
    localparam int MAX_MS     = 1000;

    localparam int ADDR_W  = $clog2(TASK_SLOTS);
    localparam int SLOT_W  = 5;
    localparam int MS_W    = 10;
    localparam int DIV_W   = MS_W + 1;
    localparam int PROD_W  = DIV_W + MS_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int ENTRY_W = 2 * MS_W;
    localparam int CNT_W   = $clog2(DIV_W);

    localparam logic [MS_W-1:0]  MAX_MS_V = MS_W'(MAX_MS);
    localparam logic [MS_W-1:0]  CAP_V    = MS_W'(MAX_MS + 1);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(MAX_MS + 1);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_ACTIVE   = 3'd2,
        ST_UNSCHED  = 3'd3,
        ST_INACTIVE = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ADMIT  = 1'b0,
        CMD_CANCEL = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_DIV,
        S_MUL,
        S_ACC,
        S_END,
        S_RESULT
    } t_state;

endpackage

// ----- rtl/core/rtaac_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module rtaac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/rta_admission_control_top.sv -----
// Admission control by response-time analysis; depends on rtaac_pkg and rtaac_ram.
// Cancel and invalid or busy admit go from accept through S_CHECK to the result register;
// admit iterates the recurrence over all slots, dividing for each slot with a shorter period (11-step divider).
// One transaction at a time; the next is taken the cycle after the result is registered,
// which waits while the previous result is still unaccepted at the output.
// Reset (synchronous) clears all slot valid bits at once; no clearing pass.
module rta_admission_control_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[4:0], budget_ms[14:5], period_ms[24:15], zero above
    input  logic [31:0] s_axis_tdata,
    // cmd[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], response_ms[12:3], zero above
    output logic [15:0] m_axis_tdata
);

    rtaac_pkg::t_state r_state, n_state;

    logic [rtaac_pkg::TASK_SLOTS-1:0] r_valid;
    logic                             r_rd_vld;

    rtaac_pkg::t_cmd              r_cmd;
    logic [rtaac_pkg::SLOT_W-1:0] r_slot;
    logic [rtaac_pkg::MS_W-1:0]   r_c;
    logic [rtaac_pkg::MS_W-1:0]   r_t;

    logic [rtaac_pkg::ADDR_W-1:0] r_j;
    logic [rtaac_pkg::MS_W-1:0]   r_r;
    logic [rtaac_pkg::MS_W-1:0]   r_acc;
    logic [rtaac_pkg::MS_W-1:0]   r_tj;
    logic [rtaac_pkg::MS_W-1:0]   r_cj;
    logic [rtaac_pkg::DIV_W-1:0]  r_div_num;
    logic [rtaac_pkg::DIV_W-1:0]  r_div_rem;
    logic [rtaac_pkg::CNT_W-1:0]  r_div_cnt;
    logic [rtaac_pkg::PROD_W-1:0] r_prod;

    rtaac_pkg::t_status           r_status;
    logic [rtaac_pkg::MS_W-1:0]   r_resp;

    logic                            r_m_tvalid;
    logic [rtaac_pkg::M_TDATA_W-1:0] r_m_tdata;

    logic                              w_ram_we;
    logic [rtaac_pkg::ADDR_W-1:0]      w_ram_addr;
    logic [rtaac_pkg::ENTRY_W-1:0]     w_ram_wdata;
    logic [rtaac_pkg::ENTRY_W-1:0]     w_ram_rdata;
    logic                              w_in_acc;
    logic                              w_out_load;
    logic [rtaac_pkg::MS_W-1:0]        w_ent_b;
    logic [rtaac_pkg::MS_W-1:0]        w_ent_p;
    logic                              w_slot_oor;
    logic                              w_vals_bad;
    logic                              w_cancel_ok;
    logic                              w_admit_go;
    logic                              w_eligible;
    logic                              w_last;
    logic                              w_conv;
    logic                              w_over;
    logic [rtaac_pkg::DIV_W-1:0]       w_rem_sh;
    logic                              w_rem_ge;
    logic [rtaac_pkg::SUM_W-1:0]       w_sum;

    rtaac_ram #(
        .WIDTH (rtaac_pkg::ENTRY_W),
        .DEPTH (rtaac_pkg::TASK_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == rtaac_pkg::S_RESULT) && (!r_m_tvalid || m_axis_tready);

    assign w_ent_b = r_rd_vld ? w_ram_rdata[rtaac_pkg::ENTRY_W-1:rtaac_pkg::MS_W] : '0;
    assign w_ent_p = r_rd_vld ? w_ram_rdata[rtaac_pkg::MS_W-1:0] : '0;

    assign w_slot_oor  = int'(r_slot) >= rtaac_pkg::TASK_SLOTS;
    assign w_vals_bad  = (r_c == '0) || (r_c > rtaac_pkg::MAX_MS_V) ||
                         (r_t == '0) || (r_t > rtaac_pkg::MAX_MS_V);
    assign w_cancel_ok = !w_slot_oor && (w_ent_b != '0) && (w_ent_p != '0);
    assign w_admit_go  = !w_vals_bad && !w_slot_oor && (w_ent_b == '0) && (w_ent_p == '0);
    assign w_eligible  = (w_ent_p != '0) && (w_ent_b != '0) && (w_ent_p < r_t);
    assign w_last      = r_j == rtaac_pkg::ADDR_W'(rtaac_pkg::TASK_SLOTS - 1);
    assign w_conv      = r_acc == r_r;
    assign w_over      = r_acc > r_t;

    assign w_rem_sh = {r_div_rem[rtaac_pkg::DIV_W-2:0], r_div_num[rtaac_pkg::DIV_W-1]};
    assign w_rem_ge = w_rem_sh >= {1'b0, r_tj};
    assign w_sum    = rtaac_pkg::SUM_W'(r_acc) + rtaac_pkg::SUM_W'(r_prod);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rtaac_pkg::S_IDLE: begin
                if (w_in_acc) n_state = rtaac_pkg::S_CHECK;
            end
            rtaac_pkg::S_CHECK: begin
                if (r_cmd == rtaac_pkg::CMD_ADMIT && w_admit_go) begin
                    n_state = rtaac_pkg::S_READ;
                end else begin
                    n_state = rtaac_pkg::S_RESULT;
                end
            end
            rtaac_pkg::S_READ: n_state = rtaac_pkg::S_EVAL;
            rtaac_pkg::S_EVAL: begin
                if (w_eligible) begin
                    n_state = rtaac_pkg::S_DIV;
                end else if (w_last) begin
                    n_state = rtaac_pkg::S_END;
                end else begin
                    n_state = rtaac_pkg::S_READ;
                end
            end
            rtaac_pkg::S_DIV: begin
                if (r_div_cnt == rtaac_pkg::CNT_W'(rtaac_pkg::DIV_W - 1)) begin
                    n_state = rtaac_pkg::S_MUL;
                end
            end
            rtaac_pkg::S_MUL: n_state = rtaac_pkg::S_ACC;
            rtaac_pkg::S_ACC: begin
                n_state = w_last ? rtaac_pkg::S_END : rtaac_pkg::S_READ;
            end
            rtaac_pkg::S_END: begin
                n_state = (w_conv || w_over) ? rtaac_pkg::S_RESULT : rtaac_pkg::S_READ;
            end
            rtaac_pkg::S_RESULT: begin
                if (w_out_load) n_state = rtaac_pkg::S_IDLE;
            end
            default: n_state = rtaac_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ram_we      = 1'b0;
        w_ram_addr    = rtaac_pkg::ADDR_W'(r_slot);
        w_ram_wdata   = {r_c, r_t};
        case (r_state)
            rtaac_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                w_ram_addr    = rtaac_pkg::ADDR_W'(s_axis_tdata[rtaac_pkg::SLOT_W-1:0]);
            end
            rtaac_pkg::S_READ: w_ram_addr = r_j;
            rtaac_pkg::S_END:  w_ram_we   = w_conv;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rtaac_pkg::S_IDLE;
            r_valid    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rtaac_pkg::S_CHECK && r_cmd == rtaac_pkg::CMD_CANCEL &&
                w_cancel_ok) begin
                r_valid[rtaac_pkg::ADDR_W'(r_slot)] <= 1'b0;
            end
            if (r_state == rtaac_pkg::S_END && w_conv) begin
                r_valid[rtaac_pkg::ADDR_W'(r_slot)] <= 1'b1;
            end
            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[w_ram_addr];
        if (w_out_load) begin
            r_m_tdata <= {3'b000, r_resp, r_status};
        end
        case (r_state)
            rtaac_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd  <= rtaac_pkg::t_cmd'(s_axis_tuser[0]);
                    r_slot <= s_axis_tdata[4:0];
                    r_c    <= s_axis_tdata[14:5];
                    r_t    <= s_axis_tdata[24:15];
                end
            end
            rtaac_pkg::S_CHECK: begin
                r_resp <= '0;
                r_r    <= '0;
                r_acc  <= r_c;
                r_j    <= '0;
                if (r_cmd == rtaac_pkg::CMD_CANCEL) begin
                    r_status <= w_cancel_ok ? rtaac_pkg::ST_OK : rtaac_pkg::ST_INACTIVE;
                end else if (w_vals_bad || w_slot_oor) begin
                    r_status <= rtaac_pkg::ST_INVALID;
                end else begin
                    r_status <= rtaac_pkg::ST_ACTIVE;
                end
            end
            rtaac_pkg::S_EVAL: begin
                if (w_eligible) begin
                    r_div_num <= rtaac_pkg::DIV_W'(r_r) + rtaac_pkg::DIV_W'(w_ent_p) -
                                 rtaac_pkg::DIV_W'(1);
                    r_div_rem <= '0;
                    r_div_cnt <= '0;
                    r_tj      <= w_ent_p;
                    r_cj      <= w_ent_b;
                end else if (!w_last) begin
                    r_j <= r_j + rtaac_pkg::ADDR_W'(1);
                end
            end
            rtaac_pkg::S_DIV: begin
                r_div_rem <= w_rem_ge ? (w_rem_sh - {1'b0, r_tj}) : w_rem_sh;
                r_div_num <= {r_div_num[rtaac_pkg::DIV_W-2:0], w_rem_ge};
                r_div_cnt <= r_div_cnt + rtaac_pkg::CNT_W'(1);
            end
            rtaac_pkg::S_MUL: begin
                r_prod <= r_div_num * r_cj;
            end
            rtaac_pkg::S_ACC: begin
                r_acc <= (w_sum > rtaac_pkg::CAP_SUM) ? rtaac_pkg::CAP_V
                                                      : w_sum[rtaac_pkg::MS_W-1:0];
                if (!w_last) r_j <= r_j + rtaac_pkg::ADDR_W'(1);
            end
            rtaac_pkg::S_END: begin
                if (w_conv) begin
                    r_status <= rtaac_pkg::ST_OK;
                    r_resp   <= r_acc;
                end else if (w_over) begin
                    r_status <= rtaac_pkg::ST_UNSCHED;
                    r_resp   <= r_acc;
                end else begin
                    r_r   <= r_acc;
                    r_acc <= r_c;
                    r_j   <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

// ----- rtl/core/rtaac_checker.sv -----
// Port-level checks for the admission control top level, bound to it below.
// Depends on rtaac_pkg.
module rtaac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic [2:0] w_status;
    logic [9:0] w_resp;

    assign w_status = m_axis_tdata[2:0];
    assign w_resp   = m_axis_tdata[12:3];

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result transaction changed while stalled");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == rtaac_pkg::ST_INVALID ||
                          w_status == rtaac_pkg::ST_ACTIVE ||
                          w_status == rtaac_pkg::ST_INACTIVE) |-> w_resp == '0)
        else $error("refused request carries a response time");

    a_ok_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == rtaac_pkg::ST_OK |-> w_resp <= rtaac_pkg::MAX_MS_V)
        else $error("admitted response time exceeds the period limit");

    a_unsched_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == rtaac_pkg::ST_UNSCHED |-> w_resp != '0)
        else $error("unschedulable result without response time");

endmodule

bind rta_admission_control_top rtaac_checker u_rtaac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_rta_admission_control_top.sv -----
// Self-checking testbench for rta_admission_control_top: admit and cancel requests with
// random stream stalls, replies checked against a built-in slot table and recurrence.
// Depends on rtaac_pkg and the RTL of the block.
module tb_rta_admission_control_top;

    import rtaac_pkg::*;

    localparam int NUM_RANDOM   = 300;
    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 36;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [MS_W-1:0]   budget;
        logic [MS_W-1:0]   period;
    } t_slot_req;

    typedef struct packed {
        t_status         status;
        logic [MS_W-1:0] response;
    } t_slot_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    t_slot_req   pending_reqs[$];
    t_slot_reply expected_replies[$];
    t_slot_req   in_flight;

    logic [MS_W-1:0] shadow_budget[TASK_SLOTS];
    logic [MS_W-1:0] shadow_period[TASK_SLOTS];

    int total_reqs   = 0;
    int sent_count   = 0;
    int reply_count  = 0;
    int errors       = 0;
    int cycle_count  = 0;

    rta_admission_control_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_req(t_cmd cmd, int slot, int budget, int period);
        t_slot_req req;
        req.cmd    = cmd;
        req.slot   = SLOT_W'(slot);
        req.budget = MS_W'(budget);
        req.period = MS_W'(period);
        pending_reqs.push_back(req);
        total_reqs++;
    endfunction

    function automatic int unsigned rta_recurrence_step(int unsigned r, int unsigned c,
                                                        int unsigned t);
        int unsigned acc;
        int unsigned tj;
        int unsigned cj;
        acc = c;
        for (int j = 0; j < TASK_SLOTS; j++) begin
            tj = shadow_period[j];
            cj = shadow_budget[j];
            if (tj != 0 && cj != 0 && tj < t) begin
                acc = acc + ((r + tj - 1) / tj) * cj;
                if (acc > MAX_MS + 1)
                    acc = MAX_MS + 1;
            end
        end
        return acc;
    endfunction

    task automatic predict_admission(t_slot_req req);
        t_slot_reply reply;
        int unsigned c;
        int unsigned t;
        int unsigned prev;
        int unsigned cur;
        c = req.budget;
        t = req.period;
        reply.status   = ST_OK;
        reply.response = '0;
        if (req.cmd == CMD_CANCEL) begin
            if (req.slot >= TASK_SLOTS || shadow_period[req.slot] == 0 ||
                shadow_budget[req.slot] == 0) begin
                reply.status = ST_INACTIVE;
            end else begin
                shadow_budget[req.slot] = '0;
                shadow_period[req.slot] = '0;
            end
        end else if (c < 1 || c > MAX_MS || t < 1 || t > MAX_MS || req.slot >= TASK_SLOTS) begin
            reply.status = ST_INVALID;
        end else if (shadow_period[req.slot] != 0 || shadow_budget[req.slot] != 0) begin
            reply.status = ST_ACTIVE;
        end else begin
            prev = c;
            cur  = 0;
            while (prev != cur && cur <= t) begin
                prev = cur;
                cur  = rta_recurrence_step(prev, c, t);
            end
            reply.response = MS_W'(cur);
            if (prev == cur) begin
                shadow_budget[req.slot] = req.budget;
                shadow_period[req.slot] = req.period;
            end else begin
                reply.status = ST_UNSCHED;
            end
        end
        expected_replies.push_back(reply);
    endtask

    task automatic note_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_admission(in_flight);
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 &&
                    ((sent_count >= 120 && sent_count < 180) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_flight = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, in_flight.period, in_flight.budget, in_flight.slot};
                    s_axis_tuser  <= in_flight.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_slot_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                reply_count++;
                if (expected_replies.size() == 0) begin
                    note_mismatch($sformatf("unexpected reply: status %0d response %0d",
                                            m_axis_tdata[2:0], m_axis_tdata[12:3]));
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tdata[2:0] != want.status)
                        note_mismatch($sformatf("reply %0d status: expected %0d, got %0d",
                                                reply_count, want.status, m_axis_tdata[2:0]));
                    if (m_axis_tdata[12:3] != want.response)
                        note_mismatch($sformatf("reply %0d response: expected %0d, got %0d",
                                                reply_count, want.response,
                                                m_axis_tdata[12:3]));
                end
            end
            m_axis_tready <= (reply_count >= 60 && reply_count < 140) ||
                             ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int roll;
        int budget;
        int period;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            shadow_budget[i] = '0;
            shadow_period[i] = '0;
        end

        add_req(CMD_CANCEL, 0, 0, 0);
        add_req(CMD_ADMIT, 0, 0, 100);
        add_req(CMD_ADMIT, 0, 1001, 100);
        add_req(CMD_ADMIT, 0, 1023, 1023);
        add_req(CMD_ADMIT, 0, 10, 0);
        add_req(CMD_ADMIT, 0, 10, 1001);
        add_req(CMD_ADMIT, 0, 1, 1000);
        add_req(CMD_ADMIT, 0, 5, 50);
        add_req(CMD_ADMIT, 31, 1000, 1000);
        add_req(CMD_ADMIT, 1, 10, 20);
        add_req(CMD_ADMIT, 2, 15, 30);
        add_req(CMD_ADMIT, 3, 995, 1000);
        add_req(CMD_ADMIT, 4, 1, 1);
        add_req(CMD_CANCEL, 1, 1023, 1023);
        add_req(CMD_CANCEL, 1, 0, 0);
        add_req(CMD_ADMIT, 2, 15, 30);
        add_req(CMD_CANCEL, 31, 0, 0);
        add_req(CMD_CANCEL, 0, 0, 0);
        add_req(CMD_CANCEL, 4, 0, 0);
        add_req(CMD_ADMIT, 5, 1000, 1000);
        add_req(CMD_CANCEL, 5, 0, 0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                budget = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_MS + 1, 1023);
                period = $urandom_range(0, 1023);
                if ($urandom_range(0, 1))
                    add_req(CMD_ADMIT, $urandom_range(0, 31), budget, period);
                else
                    add_req(CMD_ADMIT, $urandom_range(0, 31), period, budget);
            end else if (roll < 42) begin
                add_req(CMD_CANCEL, $urandom_range(0, 31), $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
            end else begin
                budget = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40)
                                                    : $urandom_range(1, MAX_MS);
                period = $urandom_range(1, MAX_MS);
                add_req(CMD_ADMIT, $urandom_range(0, 31), budget, period);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count < total_reqs)
            @(posedge i_clk);
        while (expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_replies.size() != 0)
            note_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
